### design/jrlp_pkg.sv
// ----------------------------------------------------------------------------
// jrlp_pkg
// Shared types and result codes for the reply line parser.
// ----------------------------------------------------------------------------
package jrlp_pkg;

    localparam int unsigned IdW = 64;

    // opcode of an input request
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_RESTART = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] line_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]     kind;
        logic [7:0]     data_byte;
        logic           reply_valid;
        logic           reply_ok;
        logic           has_data;
        logic [IdW-1:0] reply_id;
    } t_result;

endpackage

### design/jrlp_in_stage.sv
// ----------------------------------------------------------------------------
// jrlp_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module jrlp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  jrlp_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_full,
    output jrlp_pkg::t_item o_item
);
    import jrlp_pkg::*;

    logic  r_full;
    t_item r_item;

    assign o_ready = !r_full || i_take;
    assign o_full  = r_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### design/jrlp_core.sv
// ----------------------------------------------------------------------------
// jrlp_core
// Parser state and the per-byte next-state logic; one request per step.
// ----------------------------------------------------------------------------
module jrlp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  jrlp_pkg::t_item   i_item,
    output logic              o_res_valid,
    output jrlp_pkg::t_result o_res
);
    import jrlp_pkg::*;

    localparam logic [3:0] PH_START      = 4'd0;
    localparam logic [3:0] PH_KEY_OR_END = 4'd1;
    localparam logic [3:0] PH_STRING     = 4'd2;
    localparam logic [3:0] PH_COLON      = 4'd3;
    localparam logic [3:0] PH_STR_VALUE  = 4'd4;
    localparam logic [3:0] PH_NUM_PRE    = 4'd5;
    localparam logic [3:0] PH_NUM_SIGN   = 4'd6;
    localparam logic [3:0] PH_NUM_DIGITS = 4'd7;
    localparam logic [3:0] PH_AFTER      = 4'd8;
    localparam logic [3:0] PH_DONE       = 4'd9;
    localparam logic [3:0] PH_ERROR      = 4'd10;

    localparam logic [1:0] TGT_KEY    = 2'd0;
    localparam logic [1:0] TGT_RESULT = 2'd1;
    localparam logic [1:0] TGT_DATA   = 2'd2;

    localparam logic [3:0] KM_EMPTY  = 4'd0;
    localparam logic [3:0] KM_ID     = 4'd2;
    localparam logic [3:0] KM_RESULT = 4'd8;
    localparam logic [3:0] KM_DATA   = 4'd12;
    localparam logic [3:0] KM_MISS   = 4'd15;

    localparam logic [1:0] OK_EMPTY = 2'd0;
    localparam logic [1:0] OK_O     = 2'd1;
    localparam logic [1:0] OK_OK    = 2'd2;
    localparam logic [1:0] OK_MISS  = 2'd3;

    localparam logic [2:0] ESC_NONE  = 3'd0;
    localparam logic [2:0] ESC_START = 3'd1;
    localparam logic [2:0] ESC_HEX0  = 3'd2;
    localparam logic [2:0] ESC_HEX3  = 3'd5;

    localparam logic [IdW-1:0] ID_MIN = {1'b1, {(IdW-1){1'b0}}};
    localparam logic [IdW-1:0] ID_MAX = {1'b0, {(IdW-1){1'b1}}};

    function automatic logic [3:0] key_next(input logic [3:0] st, input logic [7:0] c);
        logic [3:0] nx;
        nx = KM_MISS;
        case (st)
            4'd0: begin
                if (c == "i") nx = 4'd1;
                else if (c == "r") nx = 4'd3;
                else if (c == "d") nx = 4'd9;
            end
            4'd1:  if (c == "d") nx = 4'd2;
            4'd3:  if (c == "e") nx = 4'd4;
            4'd4:  if (c == "s") nx = 4'd5;
            4'd5:  if (c == "u") nx = 4'd6;
            4'd6:  if (c == "l") nx = 4'd7;
            4'd7:  if (c == "t") nx = 4'd8;
            4'd9:  if (c == "a") nx = 4'd10;
            4'd10: if (c == "t") nx = 4'd11;
            4'd11: if (c == "a") nx = 4'd12;
            default: nx = KM_MISS;
        endcase
        return nx;
    endfunction

    function automatic logic is_blank4(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

    logic [3:0]     r_phase,   n_phase;
    logic [1:0]     r_target,  n_target;
    logic [3:0]     r_km,      n_km;
    logic [2:0]     r_esc,     n_esc;
    logic [15:0]    r_hex,     n_hex;
    logic [1:0]     r_okm,     n_okm;
    logic [IdW-1:0] r_mag,     n_mag;
    logic           r_neg,     n_neg;
    logic           r_has_dig, n_has_dig;
    logic [IdW-1:0] r_id,      n_id;
    logic           r_fl_id,   n_fl_id;
    logic           r_fl_res,  n_fl_res;
    logic           r_fl_ok,   n_fl_ok;
    logic           r_fl_data, n_fl_data;

    logic [7:0]     c;
    logic           is_digit;
    logic [3:0]     digit;
    logic [IdW+3:0] mag_x10;
    logic           hex_ok;
    logic [3:0]     hex_val;
    logic [15:0]    hex_next;
    logic           put;
    logic [7:0]     ch;
    logic           after_byte;

    assign c        = i_item.line_byte;
    assign is_digit = (c >= "0") && (c <= "9");
    assign digit    = c[3:0];
    // mag * 10 + d as shift-and-add; carry above 64 bits means saturation
    assign mag_x10  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                      + {{IdW{1'b0}}, digit};

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (is_digit) begin
            hex_val = c[3:0];
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            hex_val = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end
    assign hex_next = {r_hex[11:0], hex_val};

    always_comb begin
        n_phase   = r_phase;
        n_target  = r_target;
        n_km      = r_km;
        n_esc     = r_esc;
        n_hex     = r_hex;
        n_okm     = r_okm;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_has_dig = r_has_dig;
        n_id      = r_id;
        n_fl_id   = r_fl_id;
        n_fl_res  = r_fl_res;
        n_fl_ok   = r_fl_ok;
        n_fl_data = r_fl_data;
        o_res_valid = 1'b0;
        o_res       = '0;
        put         = 1'b0;
        ch          = c;
        after_byte  = 1'b0;

        if (i_item.opcode == OP_EOL) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_VERDICT;
            if (r_phase == PH_DONE && r_fl_id && r_fl_res) begin
                o_res.reply_valid = 1'b1;
                o_res.reply_ok    = r_fl_ok;
                o_res.has_data    = r_fl_data;
                o_res.reply_id    = r_id;
            end
            n_phase   = PH_START;
            n_target  = TGT_KEY;
            n_km      = KM_EMPTY;
            n_esc     = ESC_NONE;
            n_hex     = '0;
            n_okm     = OK_EMPTY;
            n_mag     = '0;
            n_neg     = 1'b0;
            n_has_dig = 1'b0;
            n_id      = '0;
            n_fl_id   = 1'b0;
            n_fl_res  = 1'b0;
            n_fl_ok   = 1'b0;
            n_fl_data = 1'b0;
        end else begin
            case (r_phase)
                PH_START: begin
                    if (c == "{") n_phase = PH_KEY_OR_END;
                    else if (!is_blank4(c)) n_phase = PH_ERROR;
                end
                PH_KEY_OR_END: begin
                    if (c == "\"") begin
                        n_phase  = PH_STRING;
                        n_target = TGT_KEY;
                        n_esc    = ESC_NONE;
                        n_hex    = '0;
                        n_km     = KM_EMPTY;
                    end else if (c == "}") begin
                        n_phase = PH_DONE;
                    end else if (!is_blank4(c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_STRING: begin
                    if (r_esc == ESC_NONE) begin
                        if (c == "\"") begin
                            // close the string
                            case (r_target)
                                TGT_KEY: begin
                                    if (r_km == KM_ID || r_km == KM_RESULT || r_km == KM_DATA)
                                        n_phase = PH_COLON;
                                    else
                                        n_phase = PH_ERROR;
                                end
                                TGT_RESULT: begin
                                    n_fl_res = 1'b1;
                                    n_fl_ok  = (r_okm == OK_OK);
                                    n_phase  = PH_AFTER;
                                end
                                default: begin
                                    n_fl_data = 1'b1;
                                    n_phase   = PH_AFTER;
                                end
                            endcase
                        end else if (c == "\\") begin
                            n_esc = ESC_START;
                        end else begin
                            put = 1'b1;
                        end
                    end else if (r_esc == ESC_START) begin
                        n_esc = ESC_NONE;
                        put   = 1'b1;
                        case (c)
                            "\"": ch = 8'h22;
                            "\\": ch = 8'h5c;
                            "/":  ch = 8'h2f;
                            "n":  ch = 8'h0a;
                            "t":  ch = 8'h09;
                            "r":  ch = 8'h0d;
                            "b":  ch = 8'h08;
                            "f":  ch = 8'h0c;
                            "u": begin
                                put   = 1'b0;
                                n_esc = ESC_HEX0;
                                n_hex = '0;
                            end
                            default: begin
                                put     = 1'b0;
                                n_phase = PH_ERROR;
                            end
                        endcase
                    end else begin
                        if (!hex_ok) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_hex = hex_next;
                            if (r_esc == ESC_HEX3) begin
                                n_esc = ESC_NONE;
                                if (hex_next > 16'h007f) begin
                                    n_phase = PH_ERROR;
                                end else begin
                                    put = 1'b1;
                                    ch  = hex_next[7:0];
                                end
                            end else begin
                                n_esc = r_esc + 3'd1;
                            end
                        end
                    end

                    if (put) begin
                        case (r_target)
                            TGT_KEY: n_km = key_next(r_km, ch);
                            TGT_RESULT: begin
                                if (r_okm == OK_EMPTY && ch == "o") n_okm = OK_O;
                                else if (r_okm == OK_O && ch == "k") n_okm = OK_OK;
                                else n_okm = OK_MISS;
                            end
                            default: begin
                                o_res_valid     = 1'b1;
                                o_res.kind      = KIND_DATA;
                                o_res.data_byte = ch;
                            end
                        endcase
                    end
                end
                PH_COLON: begin
                    if (c == ":") begin
                        if (r_km == KM_ID) begin
                            n_phase   = PH_NUM_PRE;
                            n_mag     = '0;
                            n_neg     = 1'b0;
                            n_has_dig = 1'b0;
                        end else begin
                            n_phase = PH_STR_VALUE;
                        end
                    end else if (!is_blank4(c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_STR_VALUE: begin
                    if (c == "\"") begin
                        n_phase = PH_STRING;
                        n_esc   = ESC_NONE;
                        n_hex   = '0;
                        if (r_km == KM_DATA) begin
                            n_target    = TGT_DATA;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_RESTART;
                        end else begin
                            n_target = TGT_RESULT;
                            n_okm    = OK_EMPTY;
                        end
                    end else if (!is_blank4(c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_NUM_PRE, PH_NUM_SIGN, PH_NUM_DIGITS: begin
                    if (is_digit) begin
                        n_mag     = (mag_x10[IdW+3:IdW] != 4'd0) ? {IdW{1'b1}}
                                                                  : mag_x10[IdW-1:0];
                        n_has_dig = 1'b1;
                        n_phase   = PH_NUM_DIGITS;
                    end else if (r_phase == PH_NUM_PRE) begin
                        if (c == "+" || c == "-") begin
                            n_neg   = (c == "-");
                            n_phase = PH_NUM_SIGN;
                        end else if (!is_blank4(c) && c != 8'h0b && c != 8'h0c) begin
                            n_phase = PH_ERROR;
                        end
                    end else if (r_phase == PH_NUM_SIGN || !r_has_dig) begin
                        n_phase = PH_ERROR;
                    end else begin
                        // saturate and commit, then treat the byte as after a value
                        if (r_neg)
                            n_id = r_mag[IdW-1] ? ID_MIN : (~r_mag + 64'd1);
                        else
                            n_id = r_mag[IdW-1] ? ID_MAX : r_mag;
                        n_fl_id    = 1'b1;
                        after_byte = 1'b1;
                    end
                end
                PH_AFTER: after_byte = 1'b1;
                PH_DONE: begin
                    if (!is_blank4(c)) n_phase = PH_ERROR;
                end
                default: n_phase = PH_ERROR;
            endcase

            if (after_byte) begin
                if (c == ",") n_phase = PH_KEY_OR_END;
                else if (c == "}") n_phase = PH_DONE;
                else if (!is_blank4(c)) n_phase = PH_ERROR;
                else n_phase = PH_AFTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_target  <= TGT_KEY;
            r_km      <= KM_EMPTY;
            r_esc     <= ESC_NONE;
            r_hex     <= '0;
            r_okm     <= OK_EMPTY;
            r_mag     <= '0;
            r_neg     <= 1'b0;
            r_has_dig <= 1'b0;
            r_id      <= '0;
            r_fl_id   <= 1'b0;
            r_fl_res  <= 1'b0;
            r_fl_ok   <= 1'b0;
            r_fl_data <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_target  <= n_target;
            r_km      <= n_km;
            r_esc     <= n_esc;
            r_hex     <= n_hex;
            r_okm     <= n_okm;
            r_mag     <= n_mag;
            r_neg     <= n_neg;
            r_has_dig <= n_has_dig;
            r_id      <= n_id;
            r_fl_id   <= n_fl_id;
            r_fl_res  <= n_fl_res;
            r_fl_ok   <= n_fl_ok;
            r_fl_data <= n_fl_data;
        end
    end

endmodule

### design/jrlp_out_stage.sv
// ----------------------------------------------------------------------------
// jrlp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module jrlp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jrlp_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output jrlp_pkg::t_result o_res
);
    import jrlp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held result leaves this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### design/json_reply_line_parser_unit.sv
// ----------------------------------------------------------------------------
// json_reply_line_parser_unit
// Byte-stream parser for one flat reply object per line, with data output.
// ----------------------------------------------------------------------------
// Path: the accepted request is loaded into the input register; it then steps
// the parser, and any result it yields loads the result register once free.
// Throughput: 1 request per cycle while the result register is free.
// Reset: synchronous active-low i_rst_n clears both stage valids and the
// parser state; no clearing pass is needed.
module json_reply_line_parser_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_opcode,
    input  logic [7:0]                   i_line_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_data_byte,
    output logic                         o_reply_valid,
    output logic                         o_reply_ok,
    output logic                         o_has_data,
    output logic signed [jrlp_pkg::IdW-1:0] o_reply_id
);
    import jrlp_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_full;
    logic    out_free;
    logic    step;
    logic    res_valid;
    t_result core_res;
    t_result out_res;

    assign in_item = {i_opcode, i_line_byte};

    // advance the held request only when the result register can take it
    assign step = held_full && out_free;

    jrlp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (out_free),
        .o_full  (held_full),
        .o_item  (held_item)
    );

    jrlp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    jrlp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_data_byte   = out_res.data_byte;
    assign o_reply_valid = out_res.reply_valid;
    assign o_reply_ok    = out_res.reply_ok;
    assign o_has_data    = out_res.has_data;
    assign o_reply_id    = out_res.reply_id;

endmodule
